// ===== rtl/core/assert_macros.svh =====
// Shared assertion macros for the core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge, muted while in reset.
`define CHK_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication checked on every rising clk edge, muted while in reset.
`define CHK_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/gffr_pkg.sv =====
`default_nettype none
package gffr_pkg;

	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 64;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] CH_WALL = 8'h31;
	localparam logic [7:0] CH_COIN = 8'h43;
	localparam logic [7:0] CH_EXIT = 8'h45;

	localparam logic [1:0] CLS_OPEN   = 2'd0;
	localparam logic [1:0] CLS_WALL   = 2'd1;
	localparam logic [1:0] CLS_TARGET = 2'd2;

	localparam logic [1:0] REG_MAP_ROWS  = 2'd0;
	localparam logic [1:0] REG_MAP_COLS  = 2'd1;
	localparam logic [1:0] REG_START_ROW = 2'd2;
	localparam logic [1:0] REG_START_COL = 2'd3;

	typedef struct packed {
		logic [1:0] cls;
		logic       last;
	} q_entry_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_CLEAR,
		ST_TRY_MUL,
		ST_TRY_RD,
		ST_TRY_CHK,
		ST_POP,
		ST_POP_WAIT,
		ST_NB_SEL,
		ST_SCAN_RD,
		ST_SCAN_CHK
	} back_state_t;

	function automatic logic [1:0] classify(input logic [7:0] t);
		if (t == CH_WALL) return CLS_WALL;
		if (t == CH_COIN || t == CH_EXIT) return CLS_TARGET;
		return CLS_OPEN;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/gffr_ram.sv =====
`default_nettype none
module gffr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/core/gffr_front.sv =====
`default_nettype none
`include "assert_macros.svh"
module gffr_front import gffr_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] tile,
	input  wire logic       last_cell,
	input  wire logic       in_valid,
	output logic            in_stall,
	output logic            q_valid,
	output q_entry_t        q_data,
	input  wire logic       q_pop
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	q_entry_t        slot_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   count_q;
	logic            push;

	assign in_stall = (count_q == CW'(QUEUE_DEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != '0);
	assign q_data   = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q].cls  <= classify(tile);
			slot_q[wr_q].last <= last_cell;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (q_pop) rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !q_pop) count_q <= count_q + 1'b1;
			else if (!push && q_pop) count_q <= count_q - 1'b1;
		end
	end

	`CHK_ALWAYS(a_q_bound, count_q <= CW'(QUEUE_DEPTH), "queue count over depth")
	`CHK_IMPL(a_pop_nonempty, q_pop, q_valid, "pop from empty queue")

endmodule
`default_nettype wire

// ===== rtl/core/gffr_back.sv =====
`default_nettype none
`include "assert_macros.svh"
module gffr_back import gffr_pkg::*; #(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS,
	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
	localparam int RCW   = $clog2(MAX_ROWS + 1),
	localparam int CCW   = $clog2(MAX_COLS + 1),
	localparam int CELLS = MAX_ROWS * MAX_COLS,
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1,
	localparam int TW    = $clog2(CELLS + 1)
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [RCW-1:0] rows,
	input  wire logic [CCW-1:0] cols,
	input  wire logic [5:0]     start_row,
	input  wire logic [5:0]     start_col,
	input  wire logic           q_valid,
	input  wire q_entry_t       q_data,
	output logic                q_pop,
	output logic                all_reachable,
	output logic                out_valid,
	input  wire logic           out_stall
);

	localparam int PW = RW + CCW;

	back_state_t     state_q, state_nx;
	logic [TW-1:0]   load_idx_q, clr_q, scan_q, top_q;
	logic [RW-1:0]   cand_r_q, cur_r_q, nb_r;
	logic [CW-1:0]   cand_c_q, cur_c_q, nb_c;
	logic [1:0]      nb_q;
	logic            from_start_q, fail_q, out_q, out_valid_q;
	logic [AW-1:0]   addr_q;

	logic [TW-1:0]   total, last_idx;
	logic [PW-1:0]   prod;
	logic            start_ok, nb_ok, push_ok, fail_now, slot_free, scan_done, clr_done;

	logic            cls_we, vis_we, vis_wd, stk_we;
	logic [AW-1:0]   cls_waddr, rd_addr, vis_waddr, stk_raddr;
	logic [1:0]      cls_rd;
	logic            vis_rd;
	logic [RW+CW-1:0] stk_rd;

	assign total     = TW'(rows) * TW'(cols);
	assign last_idx  = total - 1'b1;
	assign start_ok  = (32'(start_row) < 32'(rows)) && (32'(start_col) < 32'(cols));
	assign prod      = cand_r_q * cols;
	assign push_ok   = (cls_rd != CLS_WALL) && !vis_rd;
	assign fail_now  = (cls_rd == CLS_TARGET) && !vis_rd;
	assign slot_free = !out_valid_q || !out_stall;
	assign scan_done = (scan_q == last_idx);
	assign clr_done  = (clr_q == last_idx);

	// neighbor order: down, up, right, left
	always_comb begin
		nb_r  = cur_r_q;
		nb_c  = cur_c_q;
		nb_ok = 1'b0;
		case (nb_q)
			2'd0: begin
				nb_r  = cur_r_q + 1'b1;
				nb_ok = (32'(cur_r_q) + 1 < 32'(rows));
			end
			2'd1: begin
				nb_r  = cur_r_q - 1'b1;
				nb_ok = (cur_r_q != '0);
			end
			2'd2: begin
				nb_c  = cur_c_q + 1'b1;
				nb_ok = (32'(cur_c_q) + 1 < 32'(cols));
			end
			default: begin
				nb_c  = cur_c_q - 1'b1;
				nb_ok = (cur_c_q != '0);
			end
		endcase
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_LOAD:     if (q_valid && q_data.last) state_nx = ST_CLEAR;
			ST_CLEAR:    if (clr_done) state_nx = start_ok ? ST_TRY_MUL : ST_SCAN_RD;
			ST_TRY_MUL:  state_nx = ST_TRY_RD;
			ST_TRY_RD:   state_nx = ST_TRY_CHK;
			ST_TRY_CHK:  state_nx = (from_start_q || nb_q == 2'd3) ? ST_POP : ST_NB_SEL;
			ST_POP:      state_nx = (top_q == '0) ? ST_SCAN_RD : ST_POP_WAIT;
			ST_POP_WAIT: state_nx = ST_NB_SEL;
			ST_NB_SEL: begin
				if (nb_ok) state_nx = ST_TRY_MUL;
				else if (nb_q == 2'd3) state_nx = ST_POP;
			end
			ST_SCAN_RD:  state_nx = ST_SCAN_CHK;
			ST_SCAN_CHK: begin
				if (!scan_done) state_nx = ST_SCAN_RD;
				else if (slot_free) state_nx = ST_LOAD;
			end
			default:     state_nx = ST_LOAD;
		endcase
	end

	always_comb begin
		q_pop     = (state_q == ST_LOAD) && q_valid;
		cls_we    = q_pop && (load_idx_q < total);
		cls_waddr = load_idx_q[AW-1:0];
		rd_addr   = (state_q == ST_SCAN_RD || state_q == ST_SCAN_CHK) ? scan_q[AW-1:0] : addr_q;
		vis_we    = (state_q == ST_CLEAR) || ((state_q == ST_TRY_CHK) && push_ok);
		vis_waddr = (state_q == ST_CLEAR) ? clr_q[AW-1:0] : addr_q;
		vis_wd    = (state_q != ST_CLEAR);
		stk_we    = (state_q == ST_TRY_CHK) && push_ok;
		stk_raddr = AW'(top_q - 1'b1);
	end

	gffr_ram #(.WIDTH(2), .DEPTH(CELLS)) u_class (
		.clk(clk), .we(cls_we), .waddr(cls_waddr), .wdata(q_data.cls),
		.raddr(rd_addr), .rdata(cls_rd)
	);

	gffr_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visited (
		.clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wd),
		.raddr(rd_addr), .rdata(vis_rd)
	);

	gffr_ram #(.WIDTH(RW + CW), .DEPTH(CELLS)) u_stack (
		.clk(clk), .we(stk_we), .waddr(top_q[AW-1:0]), .wdata({cand_r_q, cand_c_q}),
		.raddr(stk_raddr), .rdata(stk_rd)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			cand_r_q <= RW'(start_row);
			cand_c_q <= CW'(start_col);
		end else if (state_q == ST_NB_SEL && nb_ok) begin
			cand_r_q <= nb_r;
			cand_c_q <= nb_c;
		end
		if (state_q == ST_TRY_MUL) addr_q <= AW'(prod + PW'(cand_c_q));
		if (state_q == ST_POP_WAIT) {cur_r_q, cur_c_q} <= stk_rd;
		if (state_q == ST_SCAN_CHK && scan_done && slot_free) out_q <= !(fail_q || fail_now);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			load_idx_q   <= '0;
			clr_q        <= '0;
			scan_q       <= '0;
			top_q        <= '0;
			nb_q         <= '0;
			from_start_q <= 1'b0;
			fail_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_SCAN_CHK && scan_done && slot_free) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_LOAD: begin
					if (q_valid && q_data.last) begin
						load_idx_q   <= '0;
						clr_q        <= '0;
						fail_q       <= 1'b0;
						top_q        <= '0;
						from_start_q <= 1'b1;
					end else if (cls_we) begin
						load_idx_q <= load_idx_q + 1'b1;
					end
				end
				ST_CLEAR: begin
					clr_q  <= clr_q + 1'b1;
					scan_q <= '0;
				end
				ST_TRY_CHK: begin
					if (push_ok) top_q <= top_q + 1'b1;
					if (!from_start_q && nb_q != 2'd3) nb_q <= nb_q + 1'b1;
					from_start_q <= 1'b0;
				end
				ST_POP: begin
					if (top_q != '0) top_q <= top_q - 1'b1;
					scan_q <= '0;
				end
				ST_POP_WAIT: nb_q <= '0;
				ST_NB_SEL: if (!nb_ok && nb_q != 2'd3) nb_q <= nb_q + 1'b1;
				ST_SCAN_CHK: begin
					if (fail_now) fail_q <= 1'b1;
					if (!scan_done) scan_q <= scan_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign all_reachable = out_q;
	assign out_valid     = out_valid_q;

	`CHK_ALWAYS(a_stack_bound, top_q <= TW'(CELLS), "stack over capacity")
	`CHK_IMPL(a_scan_range, state_q == ST_SCAN_CHK, scan_q < total, "scan past grid")

endmodule
`default_nettype wire

// ===== rtl/core/grid_flood_fill_reachability.sv =====
`default_nettype none
// Four-connected flood fill reachability check. Tiles stream in one beat
// each in raster order ('1' is a wall, 'C' and 'E' are targets, any other
// byte is open); the beat with last_cell set closes the grid and, once the
// fill is done, exactly one all_reachable beat comes out. Tiles are
// classified and queued by the front end and written to the class memory
// one per cycle while the back end loads, so a grid loads at one tile per
// cycle; in_stall holds the input while the queue is full. The fill then
// clears the visited map, pops cells off the stack and probes each in-grid
// neighbor, skipping neighbors off the grid edge (the class and visited
// memories share a single read address), and ends with the final target
// scan. Loading of the next grid resumes once the result is in the output
// register; the output register lets the result wait while tiles queue.
// Configuration: APB, byte addresses 0 map_rows, 4 map_cols, 8 start_row,
// 12 start_col; write only while the block is idle.
module grid_flood_fill_reachability import gffr_pkg::*; #(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic [7:0]  tile,
	input  wire logic        last_cell,
	input  wire logic        in_valid,
	output logic             in_stall,
	output logic             all_reachable,
	output logic             out_valid,
	input  wire logic        out_stall
);

	localparam int RCW = $clog2(MAX_ROWS + 1);
	localparam int CCW = $clog2(MAX_COLS + 1);

	logic [6:0]     map_rows_q, map_cols_q;
	logic [5:0]     start_row_q, start_col_q;
	logic [RCW-1:0] rows;
	logic [CCW-1:0] cols;
	logic           wr_en;
	logic           q_valid, q_pop;
	q_entry_t       q_data;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_rows_q  <= 7'd64;
			map_cols_q  <= 7'd64;
			start_row_q <= '0;
			start_col_q <= '0;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_MAP_ROWS:  map_rows_q  <= pwdata[6:0];
				REG_MAP_COLS:  map_cols_q  <= pwdata[6:0];
				REG_START_ROW: start_row_q <= pwdata[5:0];
				REG_START_COL: start_col_q <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_MAP_ROWS:  prdata = {25'd0, map_rows_q};
			REG_MAP_COLS:  prdata = {25'd0, map_cols_q};
			REG_START_ROW: prdata = {26'd0, start_row_q};
			REG_START_COL: prdata = {26'd0, start_col_q};
			default:       prdata = '0;
		endcase
	end

	// dimensions in use: clamp to 1..MAX
	always_comb begin
		if (map_rows_q == '0) rows = RCW'(1);
		else if (32'(map_rows_q) > MAX_ROWS) rows = RCW'(MAX_ROWS);
		else rows = RCW'(map_rows_q);
		if (map_cols_q == '0) cols = CCW'(1);
		else if (32'(map_cols_q) > MAX_COLS) cols = CCW'(MAX_COLS);
		else cols = CCW'(map_cols_q);
	end

	gffr_front u_front (
		.clk(clk), .arst_n(arst_n),
		.tile(tile), .last_cell(last_cell),
		.in_valid(in_valid), .in_stall(in_stall),
		.q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
	);

	gffr_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.rows(rows), .cols(cols),
		.start_row(start_row_q), .start_col(start_col_q),
		.q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
		.all_reachable(all_reachable), .out_valid(out_valid), .out_stall(out_stall)
	);

endmodule
`default_nettype wire

// ===== tb/grid_flood_fill_reachability_test.sv =====
`default_nettype none
module grid_flood_fill_reachability_test;
	import gffr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CELLS      = DEF_MAX_ROWS * DEF_MAX_COLS;
	localparam int IDLE_LIMIT = 50000;    // 16x16 fill plus long stall, several times over
	localparam int LONG_HOLD  = 3000;

	typedef struct packed {
		logic [7:0] t;
		logic       l;
	} tile_beat_t;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic [7:0]  tile;
	logic        last_cell;
	logic        in_valid;
	logic        in_stall;
	logic        all_reachable;
	logic        out_valid;
	logic        out_stall;

	grid_flood_fill_reachability u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.tile(tile), .last_cell(last_cell), .in_valid(in_valid), .in_stall(in_stall),
		.all_reachable(all_reachable), .out_valid(out_valid), .out_stall(out_stall)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Shadow of the block: registers, class map, fill scratch.
	logic [6:0]  sh_rows = 7'd64, sh_cols = 7'd64;
	logic [5:0]  sh_srow = 6'd0, sh_scol = 6'd0;
	logic [1:0]  cls_map [CELLS];
	bit          seen    [CELLS];
	logic [11:0] dfs_stk [CELLS];
	int          dfs_sp;
	int          load_idx;

	tile_beat_t  tile_q[$];      // beats waiting to be driven
	bit          reach_q[$];     // predicted all_reachable flags, oldest first
	int          n_err;
	bit          gaps_on;
	bit          long_hold_req;

	function automatic int clamp_dim(input logic [6:0] v, input int maxv);
		if (v < 1) return 1;
		if (v > maxv) return maxv;
		return int'(v);
	endfunction

	function automatic logic [1:0] tile_class_of(input logic [7:0] t);
		if (t == CH_WALL) return CLS_WALL;
		if (t == CH_COIN || t == CH_EXIT) return CLS_TARGET;
		return CLS_OPEN;
	endfunction

	// Mark on push, so the stack never exceeds the cell count.
	function automatic void mark_cell(input int r, input int c, input int cols);
		int a;
		a = r * cols + c;
		if (a >= CELLS) return;
		if (cls_map[a] == CLS_WALL || seen[a]) return;
		seen[a] = 1'b1;
		dfs_stk[dfs_sp] = 12'(a);
		dfs_sp++;
	endfunction

	function automatic bit flood_reaches_all();
		int rows, cols, total, a, r, c;
		rows  = clamp_dim(sh_rows, DEF_MAX_ROWS);
		cols  = clamp_dim(sh_cols, DEF_MAX_COLS);
		total = rows * cols;
		foreach (seen[i]) seen[i] = 1'b0;
		dfs_sp = 0;
		if (sh_srow < rows && sh_scol < cols) mark_cell(sh_srow, sh_scol, cols);
		while (dfs_sp > 0) begin
			dfs_sp--;
			a = dfs_stk[dfs_sp];
			if (a >= total) continue;
			r = a / cols;
			c = a % cols;
			if (r + 1 < rows) mark_cell(r + 1, c, cols);
			if (r > 0) mark_cell(r - 1, c, cols);
			if (c + 1 < cols) mark_cell(r, c + 1, cols);
			if (c > 0) mark_cell(r, c - 1, cols);
		end
		for (int i = 0; i < total; i++)
			if (cls_map[i] == CLS_TARGET && !seen[i]) return 1'b0;
		return 1'b1;
	endfunction

	// Input side: record every accepted tile beat, predict on the last one.
	wire in_fire  = in_valid && !in_stall;
	wire out_fire = out_valid && !out_stall;
	logic in_took;

	always @(posedge clk) begin
		int total;
		in_took <= in_fire;
		if (arst_n && in_fire) begin
			total = clamp_dim(sh_rows, DEF_MAX_ROWS) * clamp_dim(sh_cols, DEF_MAX_COLS);
			if (load_idx < total) begin
				cls_map[load_idx] = tile_class_of(tile);
				load_idx++;
			end
			if (last_cell) begin
				reach_q.push_back(flood_reaches_all());
				load_idx = 0;
			end
		end
	end

	// Driver: once the last beat is taken, new beat or gap at a falling edge.
	int gap_left;
	always @(negedge clk) begin
		tile_beat_t b;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_took) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (tile_q.size() > 0) begin
				b = tile_q.pop_front();
				tile      <= b.t;
				last_cell <= b.l;
				in_valid  <= 1'b1;
				if (gaps_on) begin
					case ($urandom_range(9))
						0, 1, 2: gap_left <= $urandom_range(3, 1);
						3:       gap_left <= $urandom_range(40, 5);
						default: gap_left <= 0;
					endcase
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stall: short random stalls, plus one long hold on request.
	int hold_left;
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (long_hold_req && hold_left == 0) begin
			long_hold_req <= 1'b0;
			hold_left     <= LONG_HOLD;
			out_stall     <= 1'b1;
		end else if (hold_left > 1) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (hold_left == 1) begin
			hold_left <= 0;
			out_stall <= 1'b0;
		end else if (gaps_on) begin
			case ($urandom_range(9))
				0, 1: out_stall <= 1'b1;
				2:    hold_left <= $urandom_range(60, 5);
				default: out_stall <= 1'b0;
			endcase
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Result checker.
	always @(posedge clk) begin
		bit want;
		if (arst_n && out_fire) begin
			if (reach_q.size() == 0) begin
				n_err++;
				if (n_err <= 10) $display("unexpected result beat: all_reachable=%0b", all_reachable);
			end else begin
				want = reach_q.pop_front();
				if (all_reachable !== want) begin
					n_err++;
					if (n_err <= 10)
						$display("all_reachable mismatch: expected %0b got %0b", want, all_reachable);
				end
			end
		end
	end

	// Watchdog on stretches with no accepted beat on any port.
	int idle_cnt;
	always @(posedge clk) begin
		if (in_fire || out_fire || psel) idle_cnt <= 0;
		else idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_MAP_ROWS:  sh_rows = val[6:0];
			REG_MAP_COLS:  sh_cols = val[6:0];
			REG_START_ROW: sh_srow = val[5:0];
			REG_START_COL: sh_scol = val[5:0];
			default: ;
		endcase
	endtask

	task automatic set_geometry(input logic [6:0] r, input logic [6:0] c,
			input logic [5:0] sr, input logic [5:0] sc);
		reg_write(REG_MAP_ROWS, 32'(r));
		reg_write(REG_MAP_COLS, 32'(c));
		reg_write(REG_START_ROW, 32'(sr));
		reg_write(REG_START_COL, 32'(sc));
	endtask

	// Sender holds until every result is back, then lets the fill settle.
	task automatic drain();
		while (tile_q.size() > 0 || in_valid || reach_q.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [7:0] rand_tile(input int wall_pct);
		int p;
		p = $urandom_range(99);
		if (p < wall_pct) return CH_WALL;
		if (p < wall_pct + 8) return CH_COIN;
		if (p < wall_pct + 14) return CH_EXIT;
		if (p < wall_pct + 18) return 8'h46;    // 'F' is plain floor
		if (p < wall_pct + 28) return 8'($urandom_range(255));
		return 8'h30;
	endfunction

	// One grid of n beats, last_cell on the final one.
	task automatic queue_grid(input int n, input int wall_pct);
		tile_beat_t b;
		for (int i = 0; i < n; i++) begin
			b.t = rand_tile(wall_pct);
			b.l = (i == n - 1);
			tile_q.push_back(b);
		end
	endtask

	task automatic queue_fixed(input logic [7:0] t, input logic l);
		tile_beat_t b;
		b.t = t;
		b.l = l;
		tile_q.push_back(b);
	endtask

	initial begin
		int rows, cols, n, sent;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		tile = '0; last_cell = 1'b0; in_valid = 1'b0; out_stall = 1'b0;
		in_took = 1'b0; gap_left = 0; hold_left = 0; idle_cnt = 0;
		load_idx = 0; n_err = 0; gaps_on = 1'b0; long_hold_req = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Full 16x16 grid: writes every class cell that any later geometry
		// reaches, so later short grids never touch an unwritten cell.
		set_geometry(7'd16, 7'd16, 6'd0, 6'd0);
		queue_grid(256, 15);
		drain();

		// Clamped dimensions: zero clamps to one, 127 to the maximum.
		set_geometry(7'd0, 7'd0, 6'd0, 6'd0);
		queue_fixed(CH_COIN, 1'b1);            // lone target at start
		queue_fixed(CH_WALL, 1'b1);            // start on a wall, no target
		queue_fixed(8'hFF, 1'b0);              // open tile fills the next one-cell grid
		queue_fixed(CH_EXIT, 1'b1);            // last beat beyond grid
		drain();
		set_geometry(7'd127, 7'd1, 6'd63, 6'd0);
		queue_grid(64, 5);
		queue_grid(30, 5);                     // short grid, tail stays stale
		drain();
		set_geometry(7'd1, 7'd127, 6'd0, 6'd63);
		queue_grid(64, 5);
		drain();
		// Start outside the grid: 1 only without targets.
		set_geometry(7'd2, 7'd2, 6'd5, 6'd0);
		repeat (4) queue_fixed(8'h2E, 1'b0);
		tile_q[$].l = 1'b1;
		queue_fixed(CH_COIN, 1'b0);
		queue_fixed(8'h46, 1'b0);
		queue_fixed(CH_WALL, 1'b0);
		queue_fixed(8'h00, 1'b1);
		drain();

		// Random phases; back pressure and gaps in all but every fourth phase.
		gaps_on = 1'b1;
		sent = 0;
		for (int ph = 0; sent < 424 || ph < 3; ph++) begin
			if (ph % 4 == 3) gaps_on = 1'b0;
			else gaps_on = 1'b1;
			rows = $urandom_range(9) == 0 ? $urandom_range(16, 1) : $urandom_range(6, 1);
			cols = $urandom_range(9) == 0 ? $urandom_range(16, 1) : $urandom_range(6, 1);
			set_geometry(7'(rows), 7'(cols),
				6'($urandom_range(5) == 0 ? $urandom_range(63) : $urandom_range(rows - 1)),
				6'($urandom_range(5) == 0 ? $urandom_range(63) : $urandom_range(cols - 1)));
			if (ph == 2) long_hold_req = 1'b1;
			for (int g = 0; g < 6; g++) begin
				case ($urandom_range(9))
					0:       n = $urandom_range(rows * cols, 1);
					1:       n = rows * cols + $urandom_range(5, 1);
					default: n = rows * cols;
				endcase
				queue_grid(n, $urandom_range(35));
				sent += n;
			end
			drain();
		end

		if (n_err == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire
